// ===== hdl/nib_pkg.sv =====
// Package for the name initial bucket block: widths, byte codes and the character fold.
package nib_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 2;
    localparam int WORD_W   = 24;
    localparam int BUCKET_W = 5;
    localparam int OUT_TDATA_W = 8;

    localparam logic [LEN_W-1:0] MAX_LEN = 2'd3;

    localparam logic [7:0] SPACE      = 8'h20;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] LEAD2      = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] LEAD3      = 8'hE0;
    localparam logic [7:0] MASK_CONT  = 8'h3F;

    localparam logic [BUCKET_W-1:0] IDX_A = 5'd0;
    localparam logic [BUCKET_W-1:0] IDX_D = 5'd3;
    localparam logic [BUCKET_W-1:0] IDX_E = 5'd4;
    localparam logic [BUCKET_W-1:0] IDX_I = 5'd8;
    localparam logic [BUCKET_W-1:0] IDX_O = 5'd14;
    localparam logic [BUCKET_W-1:0] IDX_U = 5'd20;
    localparam logic [BUCKET_W-1:0] IDX_Y = 5'd24;

    function automatic logic [BUCKET_W-1:0] fold_two(input logic [10:0] cp);
        logic [BUCKET_W-1:0] r;
        r = IDX_A;
        if (cp inside {11'h102, 11'h103}) r = IDX_A;
        else if (cp inside {11'h110, 11'h111}) r = IDX_D;
        else if (cp inside {11'h1A0, 11'h1A1}) r = IDX_O;
        else if (cp inside {11'h1AF, 11'h1B0}) r = IDX_U;
        else if (cp inside {[11'h0C0:11'h0C3], [11'h0E0:11'h0E3]}) r = IDX_A;
        else if (cp inside {[11'h0C8:11'h0CA], [11'h0E8:11'h0EA]}) r = IDX_E;
        else if (cp inside {11'h0CC, 11'h0CD, 11'h0EC, 11'h0ED}) r = IDX_I;
        else if (cp inside {[11'h0D2:11'h0D5], [11'h0F2:11'h0F5]}) r = IDX_O;
        else if (cp inside {11'h0D9, 11'h0DA, 11'h0F9, 11'h0FA}) r = IDX_U;
        else if (cp inside {11'h0DD, 11'h0FD}) r = IDX_Y;
        return r;
    endfunction

    function automatic logic [BUCKET_W-1:0] fold_three(input logic [15:0] cp);
        logic [BUCKET_W-1:0] r;
        r = IDX_A;
        if (cp inside {[16'h1EA0:16'h1EB7]}) r = IDX_A;
        else if (cp inside {[16'h1EB8:16'h1EC7]}) r = IDX_E;
        else if (cp inside {[16'h1EC8:16'h1ECB]}) r = IDX_I;
        else if (cp inside {[16'h1ECC:16'h1EE3]}) r = IDX_O;
        else if (cp inside {[16'h1EE4:16'h1EF1]}) r = IDX_U;
        else if (cp inside {[16'h1EF2:16'h1EF9]}) r = IDX_Y;
        return r;
    endfunction

    function automatic logic [BUCKET_W-1:0] classify(input logic [LEN_W-1:0] len,
                                                     input logic [WORD_W-1:0] bytes);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] d;
        logic [BUCKET_W-1:0] r;
        b0 = bytes[7:0];
        b1 = bytes[15:8];
        b2 = bytes[23:16];
        d  = 8'd0;
        r  = IDX_A;
        if (len == '0) begin
            r = IDX_A;
        end else if (!b0[7]) begin
            if (b0 inside {[8'h61:8'h7A]}) begin
                d = b0 - 8'h61;
                r = d[BUCKET_W-1:0];
            end else if (b0 inside {[8'h41:8'h5A]}) begin
                d = b0 - 8'h41;
                r = d[BUCKET_W-1:0];
            end
        end else if ((b0 & MASK_LEAD2) == LEAD2) begin
            if (len >= 2'd2) begin
                r = fold_two({b0[4:0], b1[5:0] & MASK_CONT[5:0]});
            end
        end else if ((b0 & MASK_LEAD3) == LEAD3) begin
            if (len == MAX_LEN) begin
                r = fold_three({b0[3:0], b1[5:0] & MASK_CONT[5:0], b2[5:0] & MASK_CONT[5:0]});
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/name_initial_bucket_top.sv =====
// Top level of the name initial bucket block: word tracking, word select and letter fold.

// The block takes one byte of a UTF-8 full name per cycle on the slave stream, with tlast
// on the final byte, and gives one item on the master stream for each name: the letter index
// (A=0 to Z=25) of the first character of the last non-empty word, with Vietnamese accented
// letters folded to their base letter and 0 for empty names, truncated sequences or unknown
// characters. A byte is taken every cycle unless the output is stalled with a second result
// waiting behind it; the word registers update in the cycle of the byte. After the final byte,
// one register holds the chosen word and a second holds the folded index, so input can
// continue while one result waits to be taken.
module name_initial_bucket_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [nib_pkg::BYTE_W-1:0] i_s_axis_tdata,   // [7:0] name_byte
    input  logic                       i_s_axis_tlast,   // is_last
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [nib_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata // [4:0] bucket, [7:5] zero
);
    import nib_pkg::*;

    logic [LEN_W-1:0]    r_cur_len,   n_cur_len;
    logic [WORD_W-1:0]   r_cur_bytes, n_cur_bytes;
    logic [LEN_W-1:0]    r_prev_len,  n_prev_len;
    logic [WORD_W-1:0]   r_prev_bytes, n_prev_bytes;
    logic                r_sel_valid;
    logic [LEN_W-1:0]    r_sel_len,   n_sel_len;
    logic [WORD_W-1:0]   r_sel_bytes, n_sel_bytes;
    logic                r_out_valid;
    logic [BUCKET_W-1:0] r_out_bucket;

    logic in_acc;
    logic out_free;
    logic sel_free;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign sel_free        = !r_sel_valid || out_free;
    assign o_s_axis_tready = sel_free;
    assign in_acc          = i_s_axis_tvalid && sel_free;

    always_comb begin
        n_cur_len    = r_cur_len;
        n_cur_bytes  = r_cur_bytes;
        n_prev_len   = r_prev_len;
        n_prev_bytes = r_prev_bytes;
        n_sel_len    = '0;
        n_sel_bytes  = '0;
        if (in_acc) begin
            if (i_s_axis_tdata == SPACE) begin
                if (r_cur_len != '0) begin
                    n_prev_len   = r_cur_len;
                    n_prev_bytes = r_cur_bytes;
                end
                n_cur_len   = '0;
                n_cur_bytes = '0;
            end else if (r_cur_len != MAX_LEN) begin
                n_cur_bytes[BYTE_W*r_cur_len +: BYTE_W] = i_s_axis_tdata;
                n_cur_len = r_cur_len + 2'd1;
            end
            if (n_cur_len != '0) begin
                n_sel_len   = n_cur_len;
                n_sel_bytes = n_cur_bytes;
            end else begin
                n_sel_len   = n_prev_len;
                n_sel_bytes = n_prev_bytes;
            end
            if (i_s_axis_tlast) begin
                n_cur_len    = '0;
                n_cur_bytes  = '0;
                n_prev_len   = '0;
                n_prev_bytes = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_len    <= '0;
            r_cur_bytes  <= '0;
            r_prev_len   <= '0;
            r_prev_bytes <= '0;
            r_sel_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cur_len    <= n_cur_len;
            r_cur_bytes  <= n_cur_bytes;
            r_prev_len   <= n_prev_len;
            r_prev_bytes <= n_prev_bytes;
            if (sel_free) begin
                r_sel_valid <= in_acc && i_s_axis_tlast;
            end
            if (out_free) begin
                r_out_valid <= r_sel_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel_free && in_acc && i_s_axis_tlast) begin
            r_sel_len   <= n_sel_len;
            r_sel_bytes <= n_sel_bytes;
        end
        if (out_free && r_sel_valid) begin
            r_out_bucket <= classify(r_sel_len, r_sel_bytes);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-BUCKET_W){1'b0}}, r_out_bucket};

    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_bucket <= 5'd25))
        else $error("Bucket index out of range.");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_axis_tlast) |=> (r_cur_len == '0 && r_prev_len == '0
                                        && r_sel_valid))
        else $error("Word state not cleared after the final byte.");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_len == '0) |-> (r_cur_bytes == '0))
        else $error("Empty current word holds stale bytes.");

    a_sel_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sel_valid && !out_free) |=> (r_sel_valid && $stable(r_sel_bytes)))
        else $error("Selected word lost while output stalled.");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the name initial bucket block: directed and random names streamed in, buckets checked.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] BLANK = 8'h20;
    localparam logic [4:0] LET_A = 5'd0;
    localparam logic [4:0] LET_D = 5'd3;
    localparam logic [4:0] LET_E = 5'd4;
    localparam logic [4:0] LET_I = 5'd8;
    localparam logic [4:0] LET_O = 5'd14;
    localparam logic [4:0] LET_U = 5'd20;
    localparam logic [4:0] LET_Y = 5'd24;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } t_name_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_valid = 1'b0;
    logic [nib_pkg::BYTE_W-1:0] s_data = '0;
    logic s_last = 1'b0;
    logic m_ready = 1'b0;
    logic o_s_axis_tready;
    logic o_m_axis_tvalid;
    logic [nib_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    t_name_item pending[$];
    logic [7:0] name_buf[$];
    logic [4:0] bucket_q[$];

    bit s_taken = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_id = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int items_made = 0;
    int bad_results = 0;
    int quiet_cycles = 0;

    logic [1:0]  word_len = '0;
    logic [23:0] word_bytes = '0;
    logic [1:0]  last_word_len = '0;
    logic [23:0] last_word_bytes = '0;

    name_initial_bucket_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [4:0] fold_latin(input logic [10:0] cp);
        if (cp == 11'h102 || cp == 11'h103) return LET_A;
        if (cp == 11'h110 || cp == 11'h111) return LET_D;
        if (cp == 11'h1A0 || cp == 11'h1A1) return LET_O;
        if (cp == 11'h1AF || cp == 11'h1B0) return LET_U;
        if ((cp >= 11'h0C0 && cp <= 11'h0C3) || (cp >= 11'h0E0 && cp <= 11'h0E3)) return LET_A;
        if ((cp >= 11'h0C8 && cp <= 11'h0CA) || (cp >= 11'h0E8 && cp <= 11'h0EA)) return LET_E;
        if (cp == 11'h0CC || cp == 11'h0CD || cp == 11'h0EC || cp == 11'h0ED) return LET_I;
        if ((cp >= 11'h0D2 && cp <= 11'h0D5) || (cp >= 11'h0F2 && cp <= 11'h0F5)) return LET_O;
        if (cp == 11'h0D9 || cp == 11'h0DA || cp == 11'h0F9 || cp == 11'h0FA) return LET_U;
        if (cp == 11'h0DD || cp == 11'h0FD) return LET_Y;
        return LET_A;
    endfunction

    function automatic logic [4:0] fold_viet(input logic [15:0] cp);
        if (cp >= 16'h1EA0 && cp <= 16'h1EB7) return LET_A;
        if (cp >= 16'h1EB8 && cp <= 16'h1EC7) return LET_E;
        if (cp >= 16'h1EC8 && cp <= 16'h1ECB) return LET_I;
        if (cp >= 16'h1ECC && cp <= 16'h1EE3) return LET_O;
        if (cp >= 16'h1EE4 && cp <= 16'h1EF1) return LET_U;
        if (cp >= 16'h1EF2 && cp <= 16'h1EF9) return LET_Y;
        return LET_A;
    endfunction

    function automatic logic [4:0] letter_of_word(input logic [1:0] len, input logic [23:0] w);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] diff;
        b0 = w[7:0];
        b1 = w[15:8];
        b2 = w[23:16];
        diff = 8'd0;
        if (len == 2'd0) return LET_A;
        if (b0 < 8'h80) begin
            if (b0 >= 8'h61 && b0 <= 8'h7A) diff = b0 - 8'h61;
            else if (b0 >= 8'h41 && b0 <= 8'h5A) diff = b0 - 8'h41;
            return diff[4:0];
        end
        if (b0[7:5] == 3'b110) return (len < 2'd2) ? LET_A : fold_latin({b0[4:0], b1[5:0]});
        if (b0[7:4] == 4'b1110) begin
            return (len < 2'd3) ? LET_A : fold_viet({b0[3:0], b1[5:0], b2[5:0]});
        end
        return LET_A;
    endfunction

    task automatic track_name_byte(input logic [7:0] b, input logic last);
        if (b == BLANK) begin
            if (word_len != 2'd0) begin
                last_word_len = word_len;
                last_word_bytes = word_bytes;
            end
            word_len = 2'd0;
            word_bytes = '0;
        end else if (word_len < 2'd3) begin
            word_bytes[int'(word_len)*8 +: 8] = b;
            word_len = word_len + 2'd1;
        end
        if (last) begin
            if (word_len != 2'd0) bucket_q.push_back(letter_of_word(word_len, word_bytes));
            else bucket_q.push_back(letter_of_word(last_word_len, last_word_bytes));
            word_len = '0;
            word_bytes = '0;
            last_word_len = '0;
            last_word_bytes = '0;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        t_name_item it;
        it.b = b;
        it.last = last;
        pending.push_back(it);
        items_made++;
    endtask

    task automatic flush_name();
        foreach (name_buf[k]) push_byte(name_buf[k], k == name_buf.size() - 1);
        name_buf.delete();
    endtask

    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        logic [1:0] top;
        top = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'b10;
        return {top, bits};
    endfunction

    function automatic logic [10:0] stroke_cp();
        case ($urandom_range(7))
            0: return 11'h102;
            1: return 11'h103;
            2: return 11'h110;
            3: return 11'h111;
            4: return 11'h1A0;
            5: return 11'h1A1;
            6: return 11'h1AF;
            default: return 11'h1B0;
        endcase
    endfunction

    task automatic add_lead();
        logic [10:0] cp2;
        logic [15:0] cp3;
        cp2 = '0;
        cp3 = '0;
        case ($urandom_range(11))
            0, 1: name_buf.push_back(8'h41 + 8'($urandom_range(25)));
            2, 3: name_buf.push_back(8'h61 + 8'($urandom_range(25)));
            4: name_buf.push_back(8'($urandom_range(8'h7F)));
            5, 6, 7: begin
                case ($urandom_range(2))
                    0: cp2 = 11'($urandom_range(11'h0C0, 11'h0FF));
                    1: cp2 = stroke_cp();
                    default: cp2 = 11'($urandom_range(11'h7FF));
                endcase
                name_buf.push_back({3'b110, cp2[10:6]});
                name_buf.push_back(cont_byte(cp2[5:0]));
            end
            8, 9, 10: begin
                if ($urandom_range(3) != 0) cp3 = 16'($urandom_range(16'h1E9C, 16'h1EFC));
                else cp3 = 16'($urandom_range(16'hFFFF));
                name_buf.push_back({4'b1110, cp3[15:12]});
                name_buf.push_back(cont_byte(cp3[11:6]));
                name_buf.push_back(cont_byte(cp3[5:0]));
            end
            default: name_buf.push_back(8'($urandom_range(8'h80, 8'hFF)));
        endcase
    endtask

    task automatic gen_name();
        int words;
        int tail;
        logic [7:0] b;
        if ($urandom_range(4) == 0) name_buf.push_back(BLANK);
        words = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 3);
        for (int k = 0; k < words; k++) begin
            if (k > 0) repeat ($urandom_range(1, 2)) name_buf.push_back(BLANK);
            add_lead();
            tail = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 4);
            repeat (tail) begin
                b = 8'($urandom_range(255));
                name_buf.push_back((b == BLANK) ? 8'h6E : b);
            end
        end
        if (words == 0 || $urandom_range(4) == 0) name_buf.push_back(BLANK);
        flush_name();
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(1, 6)) name_buf.push_back(8'($urandom_range(255)));
        flush_name();
    endtask

    task automatic wait_sent();
        while (pending.size() != 0 || s_valid) @(posedge i_clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int count);
        int target;
        target = items_made + count;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        while (items_made < target) begin
            if ($urandom_range(99) < 85) gen_name();
            else gen_noise();
        end
        wait_sent();
    endtask

    always @(negedge i_clk) begin
        t_name_item nxt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending.pop_front();
                s_valid <= 1'b1;
                s_data <= nxt.b;
                s_last <= nxt.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_id != hold_seen) begin
            hold_seen = hold_id;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        logic [4:0] want;
        s_taken <= s_valid && o_s_axis_tready;
        if (i_rst_n && s_valid && o_s_axis_tready) track_name_byte(s_data, s_last);
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (bucket_q.size() == 0) begin
                $display("%0t: bucket %0d with no name pending, expected none",
                         $time, o_m_axis_tdata);
                bad_results++;
            end else begin
                want = bucket_q.pop_front();
                if (o_m_axis_tdata !== {3'b000, want}) begin
                    $display("%0t: bucket mismatch, expected %0d, got %0d",
                             $time, want, o_m_axis_tdata);
                    bad_results++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_byte(8'h61, 1'b1);
        push_byte(8'h5A, 1'b1);
        push_byte(BLANK, 1'b1);
        push_byte(BLANK, 1'b0); push_byte(BLANK, 1'b1);
        push_byte(8'h35, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'hC4, 1'b0); push_byte(8'h91, 1'b1);
        push_byte(8'hC4, 1'b1);
        push_byte(8'hE1, 1'b0); push_byte(8'hBB, 1'b0); push_byte(8'hB8, 1'b1);
        push_byte(8'hE1, 1'b0); push_byte(8'hBB, 1'b1);
        push_byte(8'h62, 1'b0); push_byte(BLANK, 1'b1);
        push_byte(8'h78, 1'b0); push_byte(BLANK, 1'b0);
        push_byte(8'h79, 1'b0); push_byte(8'h7A, 1'b1);
        push_byte(8'h80, 1'b1);

        run_phase(0, 0, 100);
        run_phase(52, 0, 125);
        run_phase(0, 52, 125);
        run_phase(15, 15, 125);

        while (bucket_q.size() != 0) @(posedge i_clk);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_id++;
        repeat (30) push_byte(8'h41 + 8'($urandom_range(25)), 1'b1);
        wait_sent();

        while (bucket_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (bad_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== name_initial_bucket_top.f =====
hdl/nib_pkg.sv
hdl/name_initial_bucket_top.sv
tb/tb.sv
